>>> rtl/picr_pkg.sv
// Package for the PI current regulator core: field widths, register
// indexes, item kinds and the saturating clamp shared by the datapath.
// No dependencies.
package picr_pkg;

    localparam int ERR_W   = 24;   // current error, signed mA
    localparam int BUS_W   = 16;   // bus voltage, unsigned mV
    localparam int GAIN_W  = 20;   // Q15 gains, unsigned
    localparam int DRIVE_W = 16;   // drive voltage and integrator, signed mV
    localparam int LIM_W   = BUS_W - 1;
    localparam int Q_SHIFT = 15;

    localparam int PROD_W  = ERR_W + GAIN_W + 1;   // signed product
    localparam int TERM_W  = PROD_W - Q_SHIFT;     // product after >>> 15
    localparam int SUM_W   = TERM_W + 1;           // term plus integrator

    localparam int S_TDATA_W = ((ERR_W + BUS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DRIVE_W + 7) / 8) * 8;

    typedef enum logic [0:0] {
        REG_PROP_GAIN     = 1'b0,
        REG_INTEGRAL_GAIN = 1'b1
    } reg_index_t;

    typedef enum logic [0:0] {
        KIND_STEP  = 1'b0,
        KIND_CLEAR = 1'b1
    } item_kind_t;

    // Clamp v to [-lim, +lim]; lim is a non-negative half-bus limit.
    function automatic logic signed [SUM_W-1:0] clamp_lim(
        input logic signed [SUM_W-1:0] v,
        input logic        [LIM_W-1:0] lim
    );
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = signed'({{(SUM_W-LIM_W){1'b0}}, lim});
        lo = -hi;
        if (v > hi)
            clamp_lim = hi;
        else if (v < lo)
            clamp_lim = lo;
        else
            clamp_lim = v;
    endfunction

endpackage

>>> rtl/pi_current_regulator_antiwindup_core.sv
// PI current regulator with conditional-integration anti-windup.
// Three register stages: input word, Q15 products, integrator and result.
// Depends on picr_pkg.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------------
//  s_axis   | s_tvalid / s_tready     | tdata: error_current[23:0], bus_voltage[39:24]
//           |                         | tuser: kind (0 step, 1 clear)
//  m_axis   | m_tvalid / m_tready     | tdata: drive_voltage[15:0]; tuser: saturated
//  cfg      | cfg_we (no handshake)   | cfg_addr: 0 prop_gain, 1 integral_gain
//
// One word per cycle while m_tready is high. The integrator add and clamp
// sit in the last stage, so state feeds back to the next word. Each stage
// advances when the next is empty or moving, so bubbles collapse and
// s_tready drops only when every stage holds.
// Reset clears the gains, the integrator, the clipped flag and all valids.
module pi_current_regulator_antiwindup_core
    import picr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_addr,
    input  logic [GAIN_W-1:0]    cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,    // error_current, bus_voltage
    input  logic [0:0]           s_tuser,    // kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,    // drive_voltage
    output logic [0:0]           m_tuser     // saturated
);

    // configuration
    logic [GAIN_W-1:0] prop_gain_reg;
    logic [GAIN_W-1:0] integral_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg     <= '0;
            integral_gain_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_addr))
                REG_PROP_GAIN:     prop_gain_reg     <= cfg_wdata;
                REG_INTEGRAL_GAIN: integral_gain_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // stage control
    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;

    assign adv3     = !v3_reg || m_tready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;
    assign m_tvalid = v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= s_tvalid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
        end
    end

    // stage 1: input word
    item_kind_t               kind1_reg;
    logic signed [ERR_W-1:0]  err1_reg;
    logic        [BUS_W-1:0]  bus1_reg;

    always_ff @(posedge clk)
    begin
        if (adv1 && s_tvalid)
        begin
            kind1_reg <= item_kind_t'(s_tuser[0]);
            err1_reg  <= signed'(s_tdata[ERR_W-1:0]);
            bus1_reg  <= s_tdata[ERR_W+BUS_W-1:ERR_W];
        end
    end

    // stage 2: Q15 products, floor shift by taking the upper bits
    logic signed [GAIN_W:0]   pgain_s;
    logic signed [GAIN_W:0]   igain_s;
    logic signed [PROD_W-1:0] pprod;
    logic signed [PROD_W-1:0] iprod;

    assign pgain_s = signed'({1'b0, prop_gain_reg});
    assign igain_s = signed'({1'b0, integral_gain_reg});
    assign pprod   = PROD_W'(err1_reg) * PROD_W'(pgain_s);
    assign iprod   = PROD_W'(err1_reg) * PROD_W'(igain_s);

    item_kind_t               kind2_reg;
    logic signed [TERM_W-1:0] pterm2_reg;
    logic signed [TERM_W-1:0] inc2_reg;
    logic        [LIM_W-1:0]  lim2_reg;

    always_ff @(posedge clk)
    begin
        if (adv2 && v1_reg)
        begin
            kind2_reg  <= kind1_reg;
            pterm2_reg <= pprod[PROD_W-1:Q_SHIFT];
            inc2_reg   <= iprod[PROD_W-1:Q_SHIFT];
            lim2_reg   <= bus1_reg[BUS_W-1:1];
        end
    end

    // stage 3: conditional integration, clamps, result
    logic signed [DRIVE_W-1:0] integ_reg;
    logic signed [DRIVE_W-1:0] integ_next;
    logic                      clipped_reg;
    logic                      clipped_next;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic signed [DRIVE_W-1:0] drive_next;
    logic                      sat_reg;

    logic                      do_integ;
    logic signed [SUM_W-1:0]   integ_acc;
    logic signed [SUM_W-1:0]   integ_clamped;
    logic signed [SUM_W-1:0]   out_sum;
    logic signed [SUM_W-1:0]   out_clamped;
    logic                      fire3;

    assign fire3 = adv3 && v2_reg;

    always_comb
    begin
        // integrate unless clipped last step, except when heading back to zero
        do_integ = !clipped_reg
                   || (integ_reg > 0 && inc2_reg < 0)
                   || (integ_reg < 0 && inc2_reg > 0);
        integ_acc     = SUM_W'(integ_reg) + (do_integ ? SUM_W'(inc2_reg) : '0);
        integ_clamped = clamp_lim(integ_acc, lim2_reg);
        out_sum       = SUM_W'(pterm2_reg) + integ_clamped;
        out_clamped   = clamp_lim(out_sum, lim2_reg);
        if (kind2_reg == KIND_CLEAR)
        begin
            integ_next   = '0;
            clipped_next = 1'b0;
            drive_next   = '0;
        end
        else
        begin
            integ_next   = integ_clamped[DRIVE_W-1:0];
            clipped_next = (out_clamped != out_sum);
            drive_next   = out_clamped[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg   <= '0;
            clipped_reg <= 1'b0;
        end
        else if (fire3)
        begin
            integ_reg   <= integ_next;
            clipped_reg <= clipped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire3)
        begin
            drive_reg <= drive_next;
            sat_reg   <= clipped_next;
        end
    end

    assign m_tdata    = M_TDATA_W'(unsigned'(drive_reg));
    assign m_tuser[0] = sat_reg;

    // checks
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    a_flag_tracks_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire3 |=> (clipped_reg == m_tuser[0]))
        else $error("clipped flag differs from last saturated result");

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (fire3 && kind2_reg == KIND_CLEAR) |=> (integ_reg == '0 && !clipped_reg))
        else $error("clear word left integrator state");

    a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
        integ_reg != {1'b1, {(DRIVE_W-1){1'b0}}})
        else $error("integrator outside half-bus range");

    a_sat_needs_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (fire3 && clipped_next) |-> (out_sum != '0))
        else $error("saturation flagged on zero sum");

endmodule
